### sv/ritd_pkg.sv
// Shared types and constants for the radix integer-to-digits converter.
`timescale 1ns / 1ps

package ritd_pkg;

    localparam int IN_W      = 64;
    localparam int RADIX_W   = 6;
    localparam int REM_W     = 6;
    localparam int CHAR_W    = 7;
    localparam int STEP_BITS = 8;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX36 = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_MAX62 = 6'd62;

    localparam logic REG_RADIX = 1'b0;
    localparam logic REG_ALPHA = 1'b1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic push;
        logic start_emit;
        logic rd;
        logic out_load;
        logic idx_dec;
    } cmd_t;

    typedef struct packed {
        logic q_zero;
        logic cnt_zero;
        logic idx_zero;
        logic out_free;
    } sts_t;

    function automatic logic [CHAR_W-1:0] digit_char_f(input logic [REM_W-1:0] rem);
        logic [CHAR_W-1:0] wide;
        begin
            wide = {1'b0, rem};
            if (rem < 6'd10)
            begin
                digit_char_f = wide + 7'd48;
            end
            else if (rem < 6'd36)
            begin
                digit_char_f = wide + 7'd55;
            end
            else
            begin
                digit_char_f = wide + 7'd61;
            end
        end
    endfunction

endpackage

### sv/ritd_ctrl.sv
// Controller state machine that sequences division, digit storage and emission.
`timescale 1ns / 1ps

module ritd_ctrl #(
    parameter int VALUE_BITS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ritd_pkg::sts_t sts,
    output ritd_pkg::cmd_t cmd
);
    import ritd_pkg::*;

    localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_CYCLES - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_PUSH = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if ((step_reg == '0) && sts.q_zero)
                begin
                    if (sts.cnt_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.start_emit = 1'b1;
                        state_next     = ST_RD;
                    end
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        step_next  = '0;
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_DIV;
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.idx_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.push, cmd.rd, cmd.out_load}))
        else $error("More than one datapath command in one cycle.");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("Output register loaded while it still holds a digit.");

endmodule

### sv/ritd_dp.sv
// Datapath: radix divider, digit store and output register.
`timescale 1ns / 1ps

module ritd_dp #(
    parameter int VALUE_BITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ritd_pkg::IN_W-1:0]      value,
    input  logic [ritd_pkg::RADIX_W-1:0]   radix_cfg,
    input  logic                           alpha_cfg,
    input  ritd_pkg::cmd_t                 cmd,
    output ritd_pkg::sts_t                 sts,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ritd_pkg::CHAR_W-1:0]    digit_char,
    output logic                           last
);
    import ritd_pkg::*;

    localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS   = DIV_CYCLES * STEP_BITS;
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    logic [PAD_BITS-1:0] q_reg;
    logic [PAD_BITS-1:0] q_next;
    logic [REM_W-1:0]    rem_reg;
    logic [REM_W-1:0]    rem_next;
    logic [RADIX_W-1:0]  radix_eff_reg;
    logic [RADIX_W-1:0]  radix_eff_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [REM_W-1:0]    rd_data_reg;
    logic                out_valid_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic                last_reg;
    logic [REM_W-1:0]    mem [VALUE_BITS];

    logic [REM_W-1:0]     step_rem;
    logic [STEP_BITS-1:0] step_q;

    always_comb
    begin
        logic [REM_W:0]   trial;
        logic [REM_W-1:0] r;
        r      = rem_reg;
        trial  = '0;
        step_q = '0;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            trial = {r, q_reg[PAD_BITS-1-i]};
            if (trial >= {1'b0, radix_eff_reg})
            begin
                trial                  = trial - {1'b0, radix_eff_reg};
                step_q[STEP_BITS-1-i] = 1'b1;
            end
            r = trial[REM_W-1:0];
        end
        step_rem = r;
    end

    always_comb
    begin
        logic [RADIX_W-1:0] top;
        logic [RADIX_W-1:0] r;
        top = alpha_cfg ? RADIX_MAX62 : RADIX_MAX36;
        r   = radix_cfg;
        if (r < RADIX_MIN)
        begin
            r = RADIX_MIN;
        end
        if (r > top)
        begin
            r = top;
        end
        radix_eff_next = cmd.load ? r : radix_eff_reg;
    end

    always_comb
    begin
        q_next   = q_reg;
        rem_next = rem_reg;
        if (cmd.load)
        begin
            q_next   = PAD_BITS'(value[VALUE_BITS-1:0]);
            rem_next = '0;
        end
        else if (cmd.div_step)
        begin
            q_next   = (q_reg << STEP_BITS) | PAD_BITS'(step_q);
            rem_next = step_rem;
        end
        else if (cmd.push)
        begin
            rem_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            radix_eff_reg <= RADIX_MIN;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            radix_eff_reg <= radix_eff_next;
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.push)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.start_emit)
            begin
                idx_reg <= IDX_W'(cnt_reg - 1'b1);
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= rem_reg;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            char_reg <= digit_char_f(rd_data_reg);
            last_reg <= (idx_reg == '0);
        end
    end

    assign sts.q_zero   = (q_reg == '0);
    assign sts.cnt_zero = (cnt_reg == '0);
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < radix_eff_reg)
        else $error("Partial remainder is not below the radix.");

    a_radix_floor: assert property (@(posedge clk) disable iff (!rst_n)
        radix_eff_reg >= RADIX_MIN)
        else $error("Working radix below two.");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(VALUE_BITS))
        else $error("Digit count exceeds the digit store.");

endmodule

### sv/radix_integer_to_digits.sv
// Top level of the radix integer-to-digits converter with its register port.
`timescale 1ns / 1ps

// Converts an unsigned value into ASCII digit characters in a configured radix.
// Input channel: value with in_valid/in_stall; a transfer takes place when
// in_valid is high and in_stall is low. Output channel: digit_char and last with
// out_valid/out_stall; one transfer per digit, most significant first, with last
// set on the final digit. A value of zero gives no output transfers.
// Each digit is worked out by a run of divider steps, each retiring eight
// quotient bits per cycle, and is then pushed into the digit store; once
// all digits are in, each is read from the digit store and loaded into the
// output register, most significant first. A 64-bit value has up to 20
// digits in radix 10 and up to 64 digits in radix 2.
// One item is in work at a time; the next item is taken as soon as the final
// digit sits in the output register, even while that digit is still stalled.
// A stalled output register holds its digit and pauses emission.
// Reset sets radix to 10 and alphabet_select to 0 and empties the block.
// Configuration is to be written over the APB port only while the block is
// idle; the block itself does not enforce this.
module radix_integer_to_digits #(
    parameter int VALUE_BITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ritd_pkg::ADDR_W-1:0]    paddr,
    input  logic [ritd_pkg::DATA_W-1:0]    pwdata,
    output logic [ritd_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ritd_pkg::IN_W-1:0]      value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ritd_pkg::CHAR_W-1:0]    digit_char,
    output logic                           last
);
    import ritd_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    logic               alpha_reg;
    logic               wr_en;
    cmd_t               cmd;
    sts_t               sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
            alpha_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_RADIX: radix_reg <= pwdata[RADIX_W-1:0];
                REG_ALPHA: alpha_reg <= pwdata[0];
                default:   radix_reg <= radix_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_RADIX: prdata = DATA_W'(radix_reg);
            REG_ALPHA: prdata = DATA_W'(alpha_reg);
            default:   prdata = '0;
        endcase
    end

    ritd_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ritd_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .radix_cfg  (radix_reg),
        .alpha_cfg  (alpha_reg),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last       (last)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for the radix integer-to-digits converter.
`timescale 1ns / 1ps

module tb;

    import ritd_pkg::*;

    localparam int SETTLE_CYCLES = 750;
    localparam int HOLD_CYCLES   = 1500;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int PHASE_ITEMS   = 38;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_t;

    class digit_tracker;
        logic [RADIX_W-1:0] radix_reg;
        logic               alpha_reg;
        digit_t             digits_due[$];
        int                 errors;
        string              glyphs;

        function new();
            radix_reg = RADIX_RESET;
            alpha_reg = 1'b0;
            errors    = 0;
            glyphs    = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
        endfunction

        function logic [IN_W-1:0] eff_base();
            logic [RADIX_W-1:0] r;
            r = radix_reg;
            if (r < RADIX_MIN)
            begin
                r = RADIX_MIN;
            end
            if (alpha_reg && r > RADIX_MAX62)
            begin
                r = RADIX_MAX62;
            end
            if (!alpha_reg && r > RADIX_MAX36)
            begin
                r = RADIX_MAX36;
            end
            return IN_W'(r);
        endfunction

        function void note_value(logic [IN_W-1:0] v);
            logic [IN_W-1:0]   rest;
            logic [IN_W-1:0]   base;
            logic [CHAR_W-1:0] lsd_first[$];
            digit_t            d;
            int                k;
            rest = v;
            base = eff_base();
            while (rest != 0)
            begin
                lsd_first.push_back(CHAR_W'(glyphs[int'(rest % base)]));
                rest = rest / base;
            end
            for (k = lsd_first.size() - 1; k >= 0; k--)
            begin
                d.ch   = lsd_first[k];
                d.last = (k == 0);
                digits_due.push_back(d);
            end
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH: %s", what);
            errors++;
        endtask

        task check_digit(logic [CHAR_W-1:0] ch, logic lst);
            digit_t d;
            if (digits_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected digit 0x%02h last=%0b", ch, lst));
            end
            else
            begin
                d = digits_due.pop_front();
                if (ch !== d.ch)
                begin
                    report_mismatch($sformatf("digit 0x%02h, wanted 0x%02h", ch, d.ch));
                end
                if (lst !== d.last)
                begin
                    report_mismatch($sformatf("last %0b, wanted %0b", lst, d.last));
                end
            end
        endtask
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [IN_W-1:0]     value     = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [CHAR_W-1:0]   digit_char;
    logic                last;

    digit_tracker        tracker = new();
    int                  digits_seen = 0;
    int                  cycles = 0;

    radix_integer_to_digits dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last       (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            tracker.check_digit(digit_char, last);
            digits_seen++;
        end
    end

    // The receiver switches between random stall habits and once holds off
    // long enough for the block to back up into its input.
    initial
    begin
        int  mode;
        int  span;
        bit  held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(50, 400);
            repeat (span)
            begin
                @(posedge clk);
                if (!held && digits_seen >= 400)
                begin
                    held = 1'b1;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                else
                begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= (cycles % 3 == 0);
                    endcase
                end
            end
        end
    end

    task automatic write_register(input logic idx, input logic [DATA_W-1:0] data);
        logic ok;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_RADIX)
        begin
            tracker.radix_reg = data[RADIX_W-1:0];
        end
        else
        begin
            tracker.alpha_reg = data[0];
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_RADIX)
        begin
            ok = (prdata[RADIX_W-1:0] === data[RADIX_W-1:0]);
        end
        else
        begin
            ok = (prdata[0] === data[0]);
        end
        if (!ok)
        begin
            tracker.report_mismatch($sformatf("register %0d reads 0x%08h after writing 0x%08h",
                                              idx, prdata, data));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_mode(input logic [RADIX_W-1:0] radix, input logic alpha);
        write_register(REG_RADIX, {2'($urandom_range(0, 3)), 24'd0, radix});
        write_register(REG_ALPHA, {31'd0, alpha});
    endtask

    task automatic send_value(input logic [IN_W-1:0] v);
        in_valid <= 1'b1;
        value    <= v;
        do @(posedge clk); while (in_stall);
        tracker.note_value(v);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (tracker.digits_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] pick_value();
        logic [IN_W-1:0] base;
        logic [IN_W-1:0] p;
        logic [IN_W-1:0] v;
        int              len;
        base = tracker.eff_base();
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = IN_W'($urandom_range(1, int'(base * base)));
            3:
            begin
                p = IN_W'(1);
                repeat ($urandom_range(1, 64))
                begin
                    if (p <= {IN_W{1'b1}} / base)
                    begin
                        p = p * base;
                    end
                end
                v = $urandom_range(0, 1) ? p : p - 1;
            end
            default:
            begin
                len = $urandom_range(1, IN_W);
                v = {$urandom, $urandom};
                v = v & ({IN_W{1'b1}} >> (IN_W - len));
                v[len - 1] = 1'b1;
            end
        endcase
        return v;
    endfunction

    task automatic run_phase(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            while (burst > 0 && sent < count)
            begin
                send_value(pick_value());
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        drain();
    endtask

    initial
    begin
        logic [RADIX_W-1:0] radix_list[10];
        logic               alpha_list[10];
        int                 i;
        radix_list = '{6'd2, 6'd36, 6'd62, 6'd0, 6'd1, 6'd63, 6'd50, 6'd63, 6'd16, 6'd10};
        alpha_list = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value(64'd99);
        send_value(64'd100);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'd10000000000000000000);
        send_value(64'd1234567890123456789);
        drain();

        set_mode(6'd36, 1'b0);
        send_value(64'd35);
        send_value(64'd36);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        set_mode(6'd62, 1'b1);
        send_value(64'd61);
        send_value(64'd62);
        send_value(64'd3843);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        set_mode(6'd0, 1'b0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        drain();

        for (i = 0; i < 10; i++)
        begin
            set_mode(radix_list[i], alpha_list[i]);
            run_phase(PHASE_ITEMS);
        end
        for (i = 0; i < 2; i++)
        begin
            set_mode(RADIX_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            run_phase(PHASE_ITEMS);
        end

        if (tracker.digits_due.size() != 0)
        begin
            tracker.report_mismatch($sformatf("%0d digits never arrived",
                                              tracker.digits_due.size()));
        end
        if (tracker.errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
